/* rtl/serial_mouse_packet_decoder_assert.svh */
// Assertion macros for the serial mouse packet decoder checker.
// Needs nothing else; included by files that write concurrent checks.
`ifndef SERIAL_MOUSE_PACKET_DECODER_ASSERT_SVH
`define SERIAL_MOUSE_PACKET_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SMPD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("serial mouse decoder check failed");

// Next-cycle implication, disabled while reset is low.
`define SMPD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("serial mouse decoder check failed");

`endif

/* rtl/smpd_pkg.sv */
// Shared types, codes and protocol tables of the serial mouse packet decoder.
// Depends on nothing; imported by every module of the block.
package smpd_pkg;

  typedef logic [2:0] idx_t;
  typedef logic [2:0] mode_t;

  localparam mode_t MODE_TWO_BUTTON = 3'd0;
  localparam mode_t MODE_THREE_BYTE = 3'd1;
  localparam mode_t MODE_FIVE_BYTE  = 3'd2;
  localparam mode_t MODE_SIGN_MAG   = 3'd3;
  localparam mode_t MODE_SIGN_MAG_B = 3'd4;
  localparam mode_t MODE_BUS        = 3'd5;

  localparam logic [1:0] EV_MOVE = 2'd0;
  localparam logic [1:0] EV_DRAG = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;
  localparam logic [1:0] EV_UP   = 2'd3;

  localparam logic [2:0] REG_PROTOCOL  = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_FACTOR    = 3'd2;
  localparam logic [2:0] REG_X_LIMIT   = 3'd3;
  localparam logic [2:0] REG_Y_LIMIT   = 3'd4;

  localparam logic [7:0] DATA_REJECT = 8'h80;
  localparam logic [3:0] ACC_MAX     = 4'd8;
  localparam int         QDEPTH      = 2;

  typedef struct packed {
    mode_t       mode;
    logic [8:0]  threshold;
    logic [3:0]  factor;
    logic [15:0] x_limit;
    logic [15:0] y_limit;
  } cfg_t;

  // Undefined modes behave as the two-button protocol.
  function automatic mode_t mode_norm(input mode_t m);
    mode_t r;
    unique case (m)
      MODE_TWO_BUTTON, MODE_THREE_BYTE, MODE_FIVE_BYTE,
      MODE_SIGN_MAG, MODE_SIGN_MAG_B, MODE_BUS: r = m;
      default: r = MODE_TWO_BUTTON;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_mask(input mode_t m);
    logic [7:0] r;
    unique case (m)
      MODE_THREE_BYTE, MODE_FIVE_BYTE, MODE_BUS: r = 8'hf8;
      MODE_SIGN_MAG, MODE_SIGN_MAG_B:            r = 8'he0;
      default:                                   r = 8'h40;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_id(input mode_t m);
    logic [7:0] r;
    unique case (m)
      MODE_TWO_BUTTON: r = 8'h40;
      default:         r = 8'h80;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dat_mask(input mode_t m);
    logic [7:0] r;
    unique case (m)
      MODE_TWO_BUTTON:                r = 8'h40;
      MODE_SIGN_MAG, MODE_SIGN_MAG_B: r = 8'h80;
      default:                        r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] pkt_len(input mode_t m);
    logic [3:0] r;
    unique case (m)
      MODE_FIVE_BYTE, MODE_BUS: r = 4'd5;
      default:                  r = 4'd3;
    endcase
    return r;
  endfunction

endpackage

/* rtl/smpd_front.sv */
// Front part: header hunt, data byte filtering and packet assembly.
// Uses smpd_pkg; hands finished packets to smpd_queue.
module smpd_front import smpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    rx_byte,
  input  mode_t                         mode,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [MAX_PACKET_BYTES*8-1:0] push_data
);

  logic [7:0] bytes_r   [MAX_PACKET_BYTES];
  logic [7:0] bytes_nxt [MAX_PACKET_BYTES];
  idx_t       idx_r, idx_nxt, idx_inc;
  mode_t      m;
  logic [3:0] len, len_eff;
  logic       accept, hdr_ok, dat_bad, done;

  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    m       = mode_norm(mode);
    len     = pkt_len(m);
    len_eff = (len > 4'(MAX_PACKET_BYTES)) ? 4'(MAX_PACKET_BYTES) : len;
    hdr_ok  = (rx_byte & hdr_mask(m)) == hdr_id(m);
    dat_bad = ((rx_byte & dat_mask(m)) != 8'h00) || (rx_byte == DATA_REJECT);
    idx_inc = idx_r + idx_t'(1);
    done    = (idx_inc == idx_t'(0)) || ({1'b0, idx_inc} >= len_eff);

    idx_nxt    = idx_r;
    bytes_nxt  = bytes_r;
    push_valid = 1'b0;
    if (accept) begin
      if (idx_r == idx_t'(0)) begin
        if (hdr_ok) begin
          bytes_nxt[0] = rx_byte;
          idx_nxt      = idx_t'(1);
        end
      end else if (dat_bad) begin
        // restart collection behind the kept header
        idx_nxt = idx_t'(1);
      end else begin
        for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
          if (idx_r == idx_t'(i)) bytes_nxt[i] = rx_byte;
        end
        if (done) begin
          idx_nxt    = idx_t'(0);
          push_valid = 1'b1;
        end else begin
          idx_nxt = idx_inc;
        end
      end
    end

    for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
      push_data[i*8 +: 8] = bytes_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

/* rtl/smpd_queue.sv */
// Two-entry packet queue between the front and back parts.
// Uses smpd_pkg for the depth.
module smpd_queue import smpd_pkg::*; #(
  parameter int WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic             wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push_en, pop_en;

  assign push_ready = count_r != 2'(QDEPTH);
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = mem_r[rd_r];
  assign push_en    = push_valid && push_ready;
  assign pop_en     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt    = push_en ? ~wr_r : wr_r;
    rd_nxt    = pop_en ? ~rd_r : rd_r;
    count_nxt = count_r + 2'(push_en) - 2'(pop_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) mem_r[wr_r] <= push_data;
  end

endmodule

/* rtl/smpd_back.sv */
// Back part: packet decode and acceleration, then cursor clamp and result register.
// Uses smpd_pkg; takes packets from smpd_queue.
module smpd_back import smpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 5,
  parameter int POSITION_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          pkt_valid,
  output logic                          pkt_ready,
  input  logic [MAX_PACKET_BYTES*8-1:0] pkt_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    buttons,
  output logic signed [10:0]            delta_x,
  output logic signed [10:0]            delta_y,
  output logic [15:0]                   pos_x,
  output logic [15:0]                   pos_y,
  output logic [1:0]                    event_kind
);

  localparam logic [15:0] POS_TOP =
    (POSITION_BITS >= 16) ? 16'hffff : 16'((1 << POSITION_BITS) - 1);

  logic [7:0] pb [5];

  // bytes beyond the stored packet length read as zero
  for (genvar g = 0; g < 5; g++) begin : g_pb
    if (g < MAX_PACKET_BYTES) begin : g_have
      assign pb[g] = pkt_data[g*8 +: 8];
    end else begin : g_zero
      assign pb[g] = 8'h00;
    end
  end

  // stage A: decode and acceleration
  mode_t             m;
  logic [2:0]        btn;
  logic [7:0]        dx, dy, absx, absy;
  logic [8:0]        abs_sum;
  logic [3:0]        acc;
  logic signed [12:0] mx, my;
  logic [1:0]        ev;

  logic              a_valid_r, a_valid_nxt;
  logic [2:0]        a_btn_r;
  logic signed [10:0] a_fx_r, a_fy_r;
  logic [1:0]        a_ev_r;
  logic              load_a, adv_b;

  always_comb begin
    m = mode_norm(cfg.mode);
    unique case (m)
      MODE_THREE_BYTE, MODE_BUS: begin
        btn = ~pb[0][2:0];
        dx  = pb[1];
        dy  = 8'h00 - pb[2];
      end
      MODE_FIVE_BYTE: begin
        btn = ~pb[0][2:0];
        dx  = pb[1] + pb[3];
        dy  = 8'h00 - (pb[2] + pb[4]);
      end
      MODE_SIGN_MAG, MODE_SIGN_MAG_B: begin
        btn = pb[0][2:0];
        dx  = pb[0][4] ? pb[1] : 8'h00 - pb[1];
        dy  = pb[0][3] ? 8'h00 - pb[2] : pb[2];
      end
      default: begin
        btn = {pb[0][5], 1'b0, pb[0][4]};
        dx  = {pb[0][1:0], pb[1][5:0]};
        dy  = {pb[0][3:2], pb[2][5:0]};
      end
    endcase

    absx    = dx[7] ? 8'h00 - dx : dx;
    absy    = dy[7] ? 8'h00 - dy : dy;
    abs_sum = {1'b0, absx} + {1'b0, absy};
    if (abs_sum > cfg.threshold) begin
      acc = (cfg.factor > ACC_MAX) ? ACC_MAX : cfg.factor;
    end else begin
      acc = 4'd1;
    end
    mx = $signed({{5{dx[7]}}, dx}) * $signed({9'd0, acc});
    my = $signed({{5{dy[7]}}, dy}) * $signed({9'd0, acc});

    if ((dx != 8'h00) || (dy != 8'h00)) begin
      ev = (btn != 3'd0) ? EV_DRAG : EV_MOVE;
    end else begin
      ev = (btn != 3'd0) ? EV_DOWN : EV_UP;
    end
  end

  assign adv_b     = a_valid_r && (!out_valid || out_ready);
  assign load_a    = pkt_valid && (!a_valid_r || adv_b);
  assign pkt_ready = !a_valid_r || adv_b;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (load_a)     a_valid_nxt = 1'b1;
    else if (adv_b) a_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_btn_r <= btn;
      a_fx_r  <= mx[10:0];
      a_fy_r  <= my[10:0];
      a_ev_r  <= ev;
    end
  end

  // stage B: cursor move with clamp, result register
  logic [15:0]        cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [15:0]        top_x, top_y;
  logic signed [17:0] sum_x, sum_y;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    top_x = (cfg.x_limit < POS_TOP) ? cfg.x_limit : POS_TOP;
    top_y = (cfg.y_limit < POS_TOP) ? cfg.y_limit : POS_TOP;
    sum_x = $signed({2'b00, cur_x_r}) + 18'(a_fx_r);
    sum_y = $signed({2'b00, cur_y_r}) + 18'(a_fy_r);

    if (sum_x[17])                       cur_x_nxt = 16'd0;
    else if (sum_x[16:0] > {1'b0, top_x}) cur_x_nxt = top_x;
    else                                 cur_x_nxt = sum_x[15:0];

    if (sum_y[17])                       cur_y_nxt = 16'd0;
    else if (sum_y[16:0] > {1'b0, top_y}) cur_y_nxt = top_y;
    else                                 cur_y_nxt = sum_y[15:0];

    out_valid_nxt = out_valid_r;
    if (adv_b)          out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_x_r     <= 16'd32;
      cur_y_r     <= 16'd32;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv_b) begin
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      buttons    <= a_btn_r;
      delta_x    <= a_fx_r;
      delta_y    <= a_fy_r;
      pos_x      <= cur_x_nxt;
      pos_y      <= cur_y_nxt;
      event_kind <= a_ev_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/serial_mouse_packet_decoder.sv */
// Serial mouse packet decoder: top level with configuration registers.
// Uses smpd_pkg, smpd_front, smpd_queue and smpd_back.
//
// in_* channel: one received mouse byte per item, tdata[7:0] = rx_byte.
// out_* channel: one item per completed packet; tdata carries buttons,
// delta_x, delta_y, pos_x and pos_y, tuser carries event_kind.
// cfg_* port: APB-style registers at byte addresses 0x00 protocol_mode,
// 0x04 accel_threshold, 0x08 accel_factor, 0x0c x_limit, 0x10 y_limit.
// Write registers only while no packet is in flight.
//
// Throughput is one byte per cycle while in_tready is high. The last byte
// of a packet completes a queue entry; from there the packet passes the
// decode and acceleration stage register, then the cursor clamp and result
// register. A two-entry packet queue sits between the byte assembler and
// the decode stages; when the receiver stalls, the result register and
// decode stage hold, the queue fills, and in_tready drops once it is full.
// Reset empties the pipeline, restarts the header hunt, sets the cursor
// to 32,32 and the registers to their defaults.
module serial_mouse_packet_decoder import smpd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 5,
  parameter int POSITION_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] buttons, [13:3] delta_x, [24:14] delta_y, [40:25] pos_x,
  // [56:41] pos_y, [63:57] zero
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,   // [1:0] event_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PW = MAX_PACKET_BYTES * 8;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_we;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx)
        REG_PROTOCOL:  cfg_nxt.mode      = cfg_pwdata[2:0];
        REG_THRESHOLD: cfg_nxt.threshold = cfg_pwdata[8:0];
        REG_FACTOR:    cfg_nxt.factor    = cfg_pwdata[3:0];
        REG_X_LIMIT:   cfg_nxt.x_limit   = cfg_pwdata[15:0];
        REG_Y_LIMIT:   cfg_nxt.y_limit   = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROTOCOL:  cfg_prdata = {29'd0, cfg_r.mode};
      REG_THRESHOLD: cfg_prdata = {23'd0, cfg_r.threshold};
      REG_FACTOR:    cfg_prdata = {28'd0, cfg_r.factor};
      REG_X_LIMIT:   cfg_prdata = {16'd0, cfg_r.x_limit};
      REG_Y_LIMIT:   cfg_prdata = {16'd0, cfg_r.y_limit};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_TWO_BUTTON;
      cfg_r.threshold <= 9'd16;
      cfg_r.factor    <= 4'd2;
      cfg_r.x_limit   <= 16'd800;
      cfg_r.y_limit   <= 16'd600;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [PW-1:0] push_data, pop_data;

  smpd_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .rx_byte    (in_tdata),
    .mode       (cfg_r.mode),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  smpd_queue #(.WIDTH(PW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  logic [2:0]         buttons;
  logic signed [10:0] delta_x, delta_y;
  logic [15:0]        pos_x, pos_y;
  logic [1:0]         event_kind;

  smpd_back #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .POSITION_BITS    (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pkt_valid  (pop_valid),
    .pkt_ready  (pop_ready),
    .pkt_data   (pop_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .buttons    (buttons),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .event_kind (event_kind)
  );

  assign out_tdata = {7'd0, pos_y, pos_x, delta_y, delta_x, buttons};
  assign out_tuser = event_kind;

endmodule

/* rtl/smpd_checker.sv */
// Port-level checks of the serial mouse packet decoder, bound to the top level.
// Uses smpd_pkg and the macros of serial_mouse_packet_decoder_assert.svh.
`include "serial_mouse_packet_decoder_assert.svh"

module smpd_checker import smpd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // hold a stalled result
  `SMPD_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SMPD_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // move and release events carry no pressed button
  `SMPD_ASSERT_IMP(a_ev_nobtn, clk, rst_n,
    out_tvalid && (out_tuser == EV_MOVE || out_tuser == EV_UP), out_tdata[2:0] == 3'd0)
  // press and release events carry no motion
  `SMPD_ASSERT_IMP(a_ev_still, clk, rst_n,
    out_tvalid && (out_tuser == EV_DOWN || out_tuser == EV_UP), out_tdata[24:3] == 22'd0)

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (.*);

/* tb/smpd_report_checker.sv */
`timescale 1ns / 100ps
// Report checker for the serial mouse packet decoder: watches the byte, report
// and register channels, predicts each report and compares it. Uses smpd_pkg.
module smpd_report_checker import smpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] buttons, [13:3] delta_x, [24:14] delta_y, [40:25] pos_x,
  // [56:41] pos_y, [63:57] zero
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,   // [1:0] event_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          reports_open
);

  typedef struct packed {
    logic [2:0]  buttons;
    logic [10:0] delta_x;
    logic [10:0] delta_y;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [1:0]  kind;
  } report_t;

  report_t     pending_reports[$];
  report_t     seen_r;
  report_t     want_r;

  mode_t       mode_q;
  logic [8:0]  threshold_q;
  logic [3:0]  factor_q;
  logic [15:0] x_limit_q;
  logic [15:0] y_limit_q;

  logic [7:0]  rx_bytes[8];
  logic [2:0]  rx_idx;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;

  // Sign-extend the low byte of v.
  function automatic int s8(input int v);
    logic signed [7:0] t;
    t = v[7:0];
    return int'(t);
  endfunction

  function automatic logic [15:0] clamp_pos(input logic [15:0] pos, input int d,
                                            input logic [15:0] lim);
    int p;
    p = int'(pos) + d;
    if (p < 0) p = 0;
    if (p > int'(lim)) p = int'(lim);
    return p[15:0];
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Advance the byte assembler by one byte; queue a report when a packet completes.
  function automatic void absorb_rx_byte(input logic [7:0] b);
    mode_t      m;
    int         len;
    logic [7:0] hmask, hid, dmask;
    logic [7:0] b0, b1, b2, b3, b4;
    logic [2:0] btn;
    int         dx, dy, acc, fx, fy;
    report_t    r;

    // Undefined modes decode as the two-button protocol.
    m = (mode_q > MODE_BUS) ? MODE_TWO_BUTTON : mode_q;
    case (m)
      MODE_TWO_BUTTON: begin
        hmask = 8'h40; hid = 8'h40; dmask = 8'h40;
      end
      MODE_SIGN_MAG, MODE_SIGN_MAG_B: begin
        hmask = 8'he0; hid = 8'h80; dmask = 8'h80;
      end
      default: begin
        hmask = 8'hf8; hid = 8'h80; dmask = 8'h00;
      end
    endcase
    len = (m == MODE_FIVE_BYTE || m == MODE_BUS) ? 5 : 3;

    if (rx_idx == 3'd0) begin
      if ((b & hmask) == hid) begin
        rx_bytes[0] = b;
        rx_idx = 3'd1;
      end
      return;
    end
    // Drop a bad data byte and restart right behind the kept header.
    if ((b & dmask) != 8'h00 || b == DATA_REJECT) begin
      rx_idx = 3'd1;
      return;
    end
    rx_bytes[rx_idx] = b;
    rx_idx = rx_idx + 3'd1;
    if (rx_idx != 3'd0 && int'(rx_idx) < len) return;
    rx_idx = 3'd0;

    b0 = rx_bytes[0];
    b1 = rx_bytes[1];
    b2 = rx_bytes[2];
    b3 = rx_bytes[3];
    b4 = rx_bytes[4];
    case (m)
      MODE_THREE_BYTE, MODE_BUS: begin
        btn = ~b0[2:0];
        dx  = s8(int'(b1));
        dy  = s8(-s8(int'(b2)));
      end
      MODE_FIVE_BYTE: begin
        btn = ~b0[2:0];
        dx  = s8(s8(int'(b1)) + s8(int'(b3)));
        dy  = s8(-(s8(int'(b2)) + s8(int'(b4))));
      end
      MODE_SIGN_MAG, MODE_SIGN_MAG_B: begin
        btn = b0[2:0];
        dx  = b0[4] ? s8(int'(b1)) : s8(-int'(b1));
        dy  = b0[3] ? s8(-int'(b2)) : s8(int'(b2));
      end
      default: begin
        btn = {b0[5], 1'b0, b0[4]};
        dx  = s8(int'({b0[1:0], b1[5:0]}));
        dy  = s8(int'({b0[3:2], b2[5:0]}));
      end
    endcase

    acc = 1;
    if (((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy) > int'(threshold_q))
      acc = (factor_q > ACC_MAX) ? int'(ACC_MAX) : int'(factor_q);
    fx = dx * acc;
    fy = dy * acc;
    cursor_x = clamp_pos(cursor_x, fx, x_limit_q);
    cursor_y = clamp_pos(cursor_y, fy, y_limit_q);

    r.buttons = btn;
    r.delta_x = fx[10:0];
    r.delta_y = fy[10:0];
    r.pos_x   = cursor_x;
    r.pos_y   = cursor_y;
    if (dx != 0 || dy != 0)
      r.kind = (btn != 3'd0) ? EV_DRAG : EV_MOVE;
    else
      r.kind = (btn != 3'd0) ? EV_DOWN : EV_UP;
    pending_reports.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_reports.delete();
      mismatches  = 0;
      mode_q      = MODE_TWO_BUTTON;
      threshold_q = 9'd16;
      factor_q    = 4'd2;
      x_limit_q   = 16'd800;
      y_limit_q   = 16'd600;
      foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
      rx_idx      = 3'd0;
      cursor_x    = 16'd32;
      cursor_y    = 16'd32;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_PROTOCOL:  mode_q      = cfg_pwdata[2:0];
          REG_THRESHOLD: threshold_q = cfg_pwdata[8:0];
          REG_FACTOR:    factor_q    = cfg_pwdata[3:0];
          REG_X_LIMIT:   x_limit_q   = cfg_pwdata[15:0];
          REG_Y_LIMIT:   y_limit_q   = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen_r = {out_tdata[2:0], out_tdata[13:3], out_tdata[24:14],
                  out_tdata[40:25], out_tdata[56:41], out_tuser};
        if (pending_reports.size() == 0) begin
          $error("report with none expected: tdata %h tuser %0d", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want_r = pending_reports.pop_front();
          check_field("buttons", int'(want_r.buttons), int'(seen_r.buttons));
          check_field("delta_x", int'($signed(want_r.delta_x)),
                      int'($signed(seen_r.delta_x)));
          check_field("delta_y", int'($signed(want_r.delta_y)),
                      int'($signed(seen_r.delta_y)));
          check_field("pos_x", int'(want_r.pos_x), int'(seen_r.pos_x));
          check_field("pos_y", int'(want_r.pos_y), int'(seen_r.pos_y));
          check_field("event_kind", int'(want_r.kind), int'(seen_r.kind));
        end
      end
      if (in_tvalid && in_tready) absorb_rx_byte(in_tdata);
    end
    reports_open <= pending_reports.size();
  end

endmodule

/* tb/serial_mouse_packet_decoder_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the serial mouse packet decoder: clock, reset, byte and
// register stimulus, receiver stalls and the verdict. Uses smpd_pkg and smpd_report_checker.
module serial_mouse_packet_decoder_tb;
  import smpd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 16;
  localparam int PHASE_BYTES  = 72;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  // [2:0] buttons, [13:3] delta_x, [24:14] delta_y, [40:25] pos_x,
  // [56:41] pos_y, [63:57] zero
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;   // [1:0] event_kind
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatches;
  int          open_reports;
  int          rx_count;
  int unsigned cycle_cnt;
  logic        gaps_on;
  logic        held_off;

  serial_mouse_packet_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  smpd_report_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (mismatches),
    .reports_open (open_reports)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stretches of ready and stall, plus one long hold-off.
  initial begin
    int pick;
    held_off = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && rx_count >= 560) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end else if (pick < 90) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (gaps_on) begin
      if (pick >= 92) gap = $urandom_range(8, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rx_count++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted report has come out, then let the pipe settle.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_reports != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One well-formed packet with random content, or noise, or a broken packet.
  task automatic send_packet(input mode_t mode);
    mode_t      m;
    int         len;
    int         pick;
    logic [7:0] b;
    m = (mode > MODE_BUS) ? MODE_TWO_BUTTON : mode;
    len = (m == MODE_FIVE_BYTE || m == MODE_BUS) ? 5 : 3;
    pick = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (pick < 8) begin
      put_byte(b);
      return;
    end
    case (m)
      MODE_TWO_BUTTON:                b[6] = 1'b1;
      MODE_SIGN_MAG, MODE_SIGN_MAG_B: b[7:5] = 3'b100;
      default:                        b[7:3] = 5'b10000;
    endcase
    put_byte(b);
    for (int i = 1; i < len; i++) begin
      pick = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (pick < 2) begin
        put_byte(DATA_REJECT);
      end else if (pick < 5) begin
        put_byte(b);
      end else begin
        if (pick < 25) begin
          case ($urandom_range(0, 5))
            0: b = 8'h00;
            1: b = 8'h7f;
            2: b = 8'h81;
            3: b = 8'hff;
            4: b = 8'h3f;
            default: b = 8'hc0;
          endcase
        end
        case (m)
          MODE_TWO_BUTTON:                b[6] = 1'b0;
          MODE_SIGN_MAG, MODE_SIGN_MAG_B: b[7] = 1'b0;
          default: if (b == DATA_REJECT) b = 8'h7f;
        endcase
        put_byte(b);
      end
    end
  endtask

  function automatic logic [15:0] pick_limit(input int sel);
    logic [15:0] r;
    case (sel % 4)
      0: r = 16'd0;
      1: r = 16'hffff;
      2: r = 16'($urandom_range(0, 1000));
      default: r = 16'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  initial begin
    int          start;
    mode_t       mode;
    logic [8:0]  thr;
    logic [3:0]  fac;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 5'd0;
    cfg_pwdata  <= 32'd0;
    rx_count = 0;
    gaps_on = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two-button protocol at reset settings.
    put_byte(8'h40); put_byte(8'h00); put_byte(8'h00);  // no motion, no buttons
    put_byte(8'h7f); put_byte(8'h3f); put_byte(8'h3f);  // both buttons, -1/-1
    put_byte(8'h43); put_byte(8'h00); put_byte(8'h00);  // fast left, clamp at 0
    put_byte(8'h41); put_byte(8'h3f); put_byte(8'h3f);  // largest positive x step
    put_byte(8'h00);                                    // ignored while hunting
    put_byte(8'h60); put_byte(DATA_REJECT); put_byte(8'h45);
    put_byte(8'h00); put_byte(8'h00);                   // drops then a press
    put_byte(8'hff); put_byte(8'h00); put_byte(8'h00);
    settle();

    // Mode switch with a packet half collected: shorter, then longer.
    reg_write(REG_PROTOCOL, 32'(MODE_FIVE_BYTE));
    put_byte(8'h80); put_byte(8'h01); put_byte(8'h02);
    settle();
    reg_write(REG_PROTOCOL, 32'(MODE_TWO_BUTTON));
    put_byte(8'h05);
    settle();
    reg_write(REG_PROTOCOL, 32'(MODE_THREE_BYTE));
    put_byte(8'h87); put_byte(8'h10);
    settle();
    reg_write(REG_PROTOCOL, 32'(MODE_FIVE_BYTE));
    put_byte(8'h20); put_byte(8'h30); put_byte(8'h40);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 8) ? mode_t'(p) : mode_t'($urandom_range(0, 7));
      case (p % 4)
        0: thr = 9'd0;
        1: thr = 9'd511;
        2: thr = 9'($urandom_range(0, 64));
        default: thr = 9'($urandom_range(0, 511));
      endcase
      case (p % 5)
        0: fac = 4'd0;
        1: fac = 4'd1;
        2: fac = ACC_MAX;
        3: fac = 4'd15;
        default: fac = 4'($urandom_range(0, 15));
      endcase
      reg_write(REG_PROTOCOL, 32'(mode));
      reg_write(REG_THRESHOLD, 32'(thr));
      reg_write(REG_FACTOR, 32'(fac));
      reg_write(REG_X_LIMIT, 32'(pick_limit(p)));
      reg_write(REG_Y_LIMIT, 32'(pick_limit(p + 1)));
      gaps_on = (p % 3 != 1);
      start = rx_count;
      while (rx_count - start < PHASE_BYTES) send_packet(mode);
      settle();
    end

    if (mismatches == 0 && open_reports == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
